/* rtl/id_to_slot_allocator_macros.svh */
// Assertion macros used by the checker file of the slot allocator.
`ifndef ID_TO_SLOT_ALLOCATOR_MACROS_SVH
`define ID_TO_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ITSA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ITSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/itsa_pkg.sv */
package itsa_pkg;

   // Fixed field widths of the request and result beats.
   localparam int ID_W       = 64;
   localparam int SLOT_OUT_W = 6;
   localparam int STATUS_W   = 3;
   localparam int RSP_DATA_W = 8;

   // Request kinds.
   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND   = 3'd0,
      STATUS_NEW     = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_REMOVED = 3'd3,
      STATUS_MISSING = 3'd4
   } status_type;

   // Update commands for the identifier table.
   typedef struct packed {
      logic set_valid;
      logic clear_valid;
   } cam_cmd_type;

   // Update commands for the free stack.
   typedef struct packed {
      logic pop;
      logic push;
   } stack_cmd_type;

   // Occupancy flags of the free stack.
   typedef struct packed {
      logic empty;
      logic full;
   } stack_status_type;

endpackage

/* rtl/itsa_id_cam.sv */
module itsa_id_cam #(
   parameter int SLOT_COUNT = 64,
   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  itsa_pkg::cam_cmd_type     cmd,
   input  logic [SLOT_W-1:0]         wr_slot,
   input  logic [itsa_pkg::ID_W-1:0] id,
   output logic                      hit,
   output logic [SLOT_W-1:0]         hit_slot
);
   import itsa_pkg::*;

   logic [ID_W-1:0]       id_table_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [SLOT_COUNT-1:0] valid_in;
   logic [SLOT_COUNT-1:0] match;
   logic [SLOT_W-1:0]     slot_acc;

   // Every bound slot compares its identifier against the request.
   always_comb begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
         match[s] = valid_ff[s] && (id_table_ff[s] == id);
      end
   end

   // An identifier is bound to at most one slot, so OR-ing the matching
   // slot numbers yields the single hit.
   always_comb begin
      slot_acc = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (match[s]) begin
            slot_acc = slot_acc | SLOT_W'(s);
         end
      end
   end

   assign hit      = |match;
   assign hit_slot = slot_acc;

   // Next value of the bound marks.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.set_valid) begin
         valid_in[wr_slot] = 1'b1;
      end else if (cmd.clear_valid) begin
         valid_in[wr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Identifier storage is only read where its mark is set.
   always_ff @(posedge clock) begin
      if (cmd.set_valid) begin
         id_table_ff[wr_slot] <= id;
      end
   end

endmodule

/* rtl/itsa_free_stack.sv */
module itsa_free_stack #(
   parameter int SLOT_COUNT = 64,
   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  itsa_pkg::stack_cmd_type    cmd,
   input  logic [SLOT_W-1:0]          push_slot,
   output logic [SLOT_W-1:0]          top_slot,
   output itsa_pkg::stack_status_type stat
);
   import itsa_pkg::*;

   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // Position 0 is always the top of the stack; entries shift on push and pop.
   logic [SLOT_W-1:0] stack_ff [SLOT_COUNT];
   logic [SLOT_W-1:0] stack_in [SLOT_COUNT];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(SLOT_COUNT));
   assign top_slot   = stack_ff[0];

   // Shift the entries up on a pop and down on a push.
   always_comb begin
      stack_in = stack_ff;
      count_in = count_ff;
      if (cmd.pop && !stat.empty) begin
         for (int j = 0; j < SLOT_COUNT - 1; j++) begin
            stack_in[j] = stack_ff[j+1];
         end
         count_in = count_ff - 1'b1;
      end else if (cmd.push && !stat.full) begin
         stack_in[0] = push_slot;
         for (int j = 1; j < SLOT_COUNT; j++) begin
            stack_in[j] = stack_ff[j-1];
         end
         count_in = count_ff + 1'b1;
      end
   end

   // From reset the stack yields slots in ascending order.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SLOT_COUNT; j++) begin
            stack_ff[j] <= SLOT_W'(j);
         end
         count_ff <= CNT_W'(SLOT_COUNT);
      end else begin
         stack_ff <= stack_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/id_to_slot_allocator.sv */
// Binds 64-bit object identifiers to a pool of SLOT_COUNT slots. Each request
// beat is held in an input register, looked up against every bound slot and
// answered from a result register, so a new request is taken in every cycle
// for as long as the result side keeps up. An add returns the slot already
// bound to the identifier, or binds the most recently freed slot (slots 0, 1,
// 2 and so on after reset), or reports the pool as full. A remove frees the
// bound slot or reports the identifier as not found; slot_index is zero
// whenever no slot applies. The lookup rests on the parallel identifier
// compare and the shift-register free stack, both updated in the same cycle
// as the lookup. The bound marks clear at reset at once, with no clearing
// pass.
module id_to_slot_allocator #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [itsa_pkg::ID_W-1:0]       req_tdata,  // [63:0] object_id
   input  logic                            req_tuser,  // [0] opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [itsa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [5:0] slot_index, [7:6] zero
   output logic [itsa_pkg::STATUS_W-1:0]   rsp_tuser   // [2:0] status
);
   import itsa_pkg::*;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Input register.
   logic             held_valid_ff;
   logic             held_valid_in;
   opcode_type       held_op_ff;
   logic [ID_W-1:0]  held_id_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   status_type            rsp_status_ff;

   logic             advance;
   logic             fire;
   logic             req_accept;

   logic             hit;
   logic [SLOT_W-1:0] hit_slot;
   logic [SLOT_W-1:0] top_slot;
   stack_status_type stack_stat;

   cam_cmd_type      cam_cmd;
   stack_cmd_type    stack_cmd;
   logic [SLOT_W-1:0] cam_slot;
   logic [SLOT_W-1:0] res_slot;
   status_type       res_status;

   // Handshake: the held request moves on when the result register is free.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = held_valid_ff && advance;
   assign req_tready = !held_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   itsa_id_cam #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_id_cam (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cam_cmd),
      .wr_slot  (cam_slot),
      .id       (held_id_ff),
      .hit      (hit),
      .hit_slot (hit_slot)
   );

   itsa_free_stack #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (stack_cmd),
      .push_slot (hit_slot),
      .top_slot  (top_slot),
      .stat      (stack_stat)
   );

   // Decide the outcome of the held request and the state updates it causes.
   always_comb begin
      cam_cmd    = '0;
      stack_cmd  = '0;
      cam_slot   = hit_slot;
      res_slot   = '0;
      res_status = STATUS_MISSING;
      case (held_op_ff)
         OP_ADD: begin
            if (hit) begin
               res_slot   = hit_slot;
               res_status = STATUS_FOUND;
            end else if (stack_stat.empty) begin
               res_status = STATUS_FULL;
            end else begin
               res_slot          = top_slot;
               res_status        = STATUS_NEW;
               cam_slot          = top_slot;
               cam_cmd.set_valid = fire;
               stack_cmd.pop     = fire;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               res_slot            = hit_slot;
               res_status          = STATUS_REMOVED;
               cam_cmd.clear_valid = fire;
               stack_cmd.push      = fire;
            end
         end
         default: begin
            res_status = STATUS_MISSING;
         end
      endcase
   end

   // Next values of the control registers.
   always_comb begin
      held_valid_in = held_valid_ff;
      if (req_accept) begin
         held_valid_in = 1'b1;
      end else if (fire) begin
         held_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers load with their beat.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         held_op_ff <= opcode_type'(req_tuser);
         held_id_ff <= req_tdata;
      end
      if (fire) begin
         rsp_slot_ff   <= SLOT_OUT_W'(res_slot);
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_slot_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* rtl/itsa_checker.sv */
`include "id_to_slot_allocator_macros.svh"

module itsa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [itsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [itsa_pkg::STATUS_W-1:0]   rsp_tuser
);
   import itsa_pkg::*;

   // A stalled result beat keeps its contents.
   `ITSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed while stalled")

   // A result that names no slot carries slot zero.
   `ITSA_ASSERT_IMPLIES(a_no_slot_zero, clock, reset, rsp_tvalid && (rsp_tuser == STATUS_FULL || rsp_tuser == STATUS_MISSING), rsp_tdata == '0, "slot index not zero on a result without a slot")

   // With the result stalled and a request just taken, no further request
   // is taken until the result side moves.
   `ITSA_ASSERT_NEXT(a_backpressure, clock, reset, rsp_tvalid && !rsp_tready && req_tvalid && req_tready, !req_tready || rsp_tready, "request taken with both stages full")

endmodule

bind id_to_slot_allocator itsa_checker u_itsa_checker (.*);
